[hdl/text_console_writer_unit_assert.svh]
// Assertion helpers for the text console writer.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// The condition holds in the same cycle, or the sequence starts in that cycle.
`define TCW_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// The condition holds in the following cycle.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: the item formats,
// the command and character codes, and the sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS_DEF        = 80;
  localparam int ROWS_DEF        = 25;
  localparam int STORE_CELLS_DEF = 8192;

  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  TEXT_ATTR  = 8'h07;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DEL = 8'h7F;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } tcw_cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [12:0] cell_index;
    logic        end_of_write;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [12:0] cursor_cell;
    logic [12:0] window_start;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_COPY_END,
    ST_BLANK,
    ST_POST
  } tcw_state_t;

  // What is left to do once a scroll has finished.
  typedef enum logic [1:0] {
    POST_NONE,
    POST_CR,
    POST_PUT
  } tcw_post_t;

endpackage

[hdl/tcw_cell_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Video cell store: one write port, one read port, registered read data.
// A read of the entry written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [15:0]              wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [15:0]              rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/tcw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Console sequencer: decodes items, keeps the write position, column, row,
// window base and cursor latch, and walks the cell store for clears,
// scroll blanking and screen relocation.
// ----------------------------------------------------------------------------
module tcw_ctrl #(
  parameter int COLS        = 80,
  parameter int ROWS        = 25,
  parameter int STORE_CELLS = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  tcw_pkg::tcw_in_t               in_item,
  output logic                           busy,
  output logic                           out_strobe,
  output tcw_pkg::tcw_out_t              out_item,
  output logic                           ram_we,
  output logic [$clog2(STORE_CELLS)-1:0] ram_waddr,
  output logic [15:0]                    ram_wdata,
  output logic [$clog2(STORE_CELLS)-1:0] ram_raddr,
  input  logic [15:0]                    ram_rdata
);

  import tcw_pkg::*;

  localparam int AW    = $clog2(STORE_CELLS);
  localparam int CLW   = $clog2(COLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CNT_W = $clog2(ROWS * COLS);

  localparam logic [AW-1:0]  LAST     = AW'(STORE_CELLS - 1);
  localparam logic [AW:0]    STORE_X  = (AW + 1)'(STORE_CELLS);
  localparam logic [AW-1:0]  COLS_A   = AW'(COLS);
  localparam logic [AW-1:0]  SCR_MOD  = AW'((ROWS * COLS) % STORE_CELLS);
  localparam logic [CLW-1:0] COLS_C   = CLW'(COLS);
  localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
  localparam logic [CNT_W-1:0] SCR_LAST  = CNT_W'(ROWS * COLS - 1);
  localparam logic [CNT_W-1:0] COLS_LAST = CNT_W'(COLS - 1);
  // A scroll fits in place while the window base stays below this value.
  localparam int FIT_LIMIT = STORE_CELLS - ROWS * COLS - COLS;

  function automatic logic [AW-1:0] inc_w(input logic [AW-1:0] a);
    return (a == LAST) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] dec_w(input logic [AW-1:0] a);
    return (a == '0) ? LAST : a - AW'(1);
  endfunction

  function automatic logic [AW-1:0] add_w(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= STORE_X) ? AW'(s - STORE_X) : AW'(s);
  endfunction

  function automatic logic [AW-1:0] sub_w(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + STORE_X - {1'b0, b};
    return (a >= b) ? (a - b) : AW'(s);
  endfunction

  tcw_state_t     state_r, state_nxt;
  logic [AW-1:0]  wb_r, wb_nxt;
  logic [AW-1:0]  wc_r, wc_nxt;
  logic [CLW-1:0] col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [AW-1:0]  cursor_r, cursor_nxt;
  logic [AW-1:0]  ptr_r, ptr_nxt;
  logic           clr_rep_r, clr_rep_nxt;
  logic           out_strobe_r, out_strobe_nxt;
  logic [AW-1:0]  dst_r, dst_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]     char_r, char_nxt;
  logic           eow_r, eow_nxt;
  tcw_post_t      post_r, post_nxt;
  tcw_out_t       out_r, out_nxt;

  logic           fin;
  logic           fin_put;
  logic           go_scroll;
  logic           wrap;
  logic [CLW-1:0] col_t;
  logic [AW-1:0]  wc_t;
  logic [15:0]    rd_sel;
  logic           fits;

  assign fits  = (FIT_LIMIT > 0) && (32'(wb_r) < FIT_LIMIT);
  assign wrap  = (col_r >= COLS_C);
  assign col_t = wrap ? (col_r - COLS_C) : col_r;

  always_comb begin
    state_nxt      = state_r;
    wb_nxt         = wb_r;
    wc_nxt         = wc_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    cursor_nxt     = cursor_r;
    ptr_nxt        = ptr_r;
    clr_rep_nxt    = clr_rep_r;
    dst_nxt        = dst_r;
    cnt_nxt        = cnt_r;
    char_nxt       = char_r;
    eow_nxt        = eow_r;
    post_nxt       = post_r;
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = wc_r;
    ram_wdata      = BLANK_CELL;
    ram_raddr      = ptr_r;
    fin            = 1'b0;
    fin_put        = 1'b0;
    go_scroll      = 1'b0;
    wc_t           = add_w(wc_r, COLS_A);
    rd_sel         = '0;

    case (state_r)
      ST_IDLE: begin
        ram_raddr = AW'(in_item.cell_index);
        if (start) begin
          char_nxt = in_item.char_code;
          eow_nxt  = in_item.end_of_write;
          case (in_item.cmd)
            CMD_PUT: begin
              fin     = 1'b1;
              fin_put = 1'b1;
              case (in_item.char_code)
                CH_BS: begin
                  if (col_r != '0) begin
                    col_nxt   = col_r - CLW'(1);
                    wc_nxt    = dec_w(wc_r);
                    ram_we    = 1'b1;
                    ram_waddr = dec_w(wc_r);
                  end
                end
                CH_LF, CH_FF: begin
                  post_nxt = (in_item.char_code == CH_LF) ? POST_CR : POST_NONE;
                  if (row_r != ROW_LAST) begin
                    row_nxt = row_r + RW'(1);
                    if (in_item.char_code == CH_LF) begin
                      wc_nxt  = sub_w(wc_t, AW'(col_r));
                      col_nxt = '0;
                    end else begin
                      wc_nxt = wc_t;
                    end
                  end else begin
                    go_scroll = 1'b1;
                  end
                end
                CH_CR: begin
                  wc_nxt  = sub_w(wc_r, AW'(col_r));
                  col_nxt = '0;
                end
                CH_DEL: begin
                  ram_we = 1'b1;
                end
                CH_NUL, CH_BEL, CH_HT, CH_VT: begin
                end
                default: begin
                  if (wrap && (row_r == ROW_LAST)) begin
                    // Past the end of the last row: wrap needs a scroll first.
                    col_nxt   = col_t;
                    wc_nxt    = sub_w(wc_r, COLS_A);
                    post_nxt  = POST_PUT;
                    go_scroll = 1'b1;
                  end else begin
                    // Stepping back one row and down one row leaves the
                    // write position where it was.
                    if (wrap) begin
                      row_nxt = row_r + RW'(1);
                    end
                    ram_we    = 1'b1;
                    ram_wdata = {TEXT_ATTR, in_item.char_code};
                    wc_nxt    = inc_w(wc_r);
                    col_nxt   = col_t + CLW'(1);
                  end
                end
              endcase
            end
            CMD_READ: begin
              if ({2'b00, in_item.cell_index} < 15'(STORE_CELLS)) begin
                state_nxt = ST_READ;
              end else begin
                fin = 1'b1;
              end
            end
            CMD_CLEAR: begin
              wb_nxt      = '0;
              wc_nxt      = '0;
              col_nxt     = '0;
              row_nxt     = '0;
              cursor_nxt  = '0;
              ptr_nxt     = '0;
              clr_rep_nxt = 1'b1;
              state_nxt   = ST_CLEAR;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        rd_sel    = ram_rdata;
        fin       = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ptr_nxt   = inc_w(ptr_r);
        if (ptr_r == LAST) begin
          clr_rep_nxt = 1'b0;
          fin         = clr_rep_r;
          state_nxt   = ST_IDLE;
        end
      end
      ST_COPY: begin
        // Read one source cell per cycle; write the cell read last cycle.
        ram_we    = (cnt_r != '0);
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        ptr_nxt   = inc_w(ptr_r);
        if (cnt_r != '0) begin
          dst_nxt = inc_w(dst_r);
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == SCR_LAST) begin
          state_nxt = ST_COPY_END;
        end
      end
      ST_COPY_END: begin
        ram_we    = 1'b1;
        ram_waddr = dst_r;
        ram_wdata = ram_rdata;
        wc_nxt    = sub_w(wc_r, wb_r);
        wb_nxt    = '0;
        ptr_nxt   = SCR_MOD;
        cnt_nxt   = '0;
        state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ptr_nxt   = inc_w(ptr_r);
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == COLS_LAST) begin
          wb_nxt    = add_w(wb_r, COLS_A);
          wc_nxt    = wc_t;
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        case (post_r)
          POST_CR: begin
            wc_nxt  = sub_w(wc_r, AW'(col_r));
            col_nxt = '0;
          end
          POST_PUT: begin
            ram_we    = 1'b1;
            ram_wdata = {TEXT_ATTR, char_r};
            wc_nxt    = inc_w(wc_r);
            col_nxt   = col_r + CLW'(1);
          end
          default: begin
          end
        endcase
        fin       = 1'b1;
        fin_put   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (go_scroll) begin
      fin     = 1'b0;
      fin_put = 1'b0;
      cnt_nxt = '0;
      if (fits) begin
        ptr_nxt   = add_w(wb_r, SCR_MOD);
        state_nxt = ST_BLANK;
      end else begin
        // No room below the window: move the screen back to cell zero first.
        ptr_nxt   = wb_r;
        dst_nxt   = '0;
        state_nxt = ST_COPY;
      end
    end

    if (fin) begin
      if (fin_put && eow_nxt) begin
        cursor_nxt = wc_nxt;
      end
      out_strobe_nxt       = 1'b1;
      out_nxt.read_data    = rd_sel;
      out_nxt.cursor_cell  = 13'(cursor_nxt);
      out_nxt.window_start = 13'(wb_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      wb_r         <= '0;
      wc_r         <= '0;
      col_r        <= '0;
      row_r        <= '0;
      cursor_r     <= '0;
      ptr_r        <= '0;
      clr_rep_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wb_r         <= wb_nxt;
      wc_r         <= wc_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      cursor_r     <= cursor_nxt;
      ptr_r        <= ptr_nxt;
      clr_rep_r    <= clr_rep_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r  <= dst_nxt;
    cnt_r  <= cnt_nxt;
    char_r <= char_nxt;
    eow_r  <= eow_nxt;
    post_r <= post_nxt;
    out_r  <= out_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

[hdl/text_console_writer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console engine: a store of character/attribute cells with a
// scrolling visible window, driven by write, read and clear items.
// ----------------------------------------------------------------------------
// Usage: an item is taken at a rising edge where start is high and busy is
// low. Each item gives one result on out_item, marked by out_strobe for a
// single cycle; the receiver must take it, there is no back pressure. The
// result holds the read data (zero unless a cell was read), the cursor latch
// and the window start after the item.
// Item flow: control codes and printable characters that do not scroll
// finish without leaving idle; reads go through one cell store read. A scroll
// blanks one row through the single write port; when the window base leaves
// no room below the window, the screen is first copied back to cell zero. A
// clear item sweeps every cell of the store before its result.
// Results come from an output register, so the next item may be taken in the
// cycle its predecessor's result is shown.
// After reset the block clears every cell of the store with busy high and
// gives no result for that pass.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
  parameter int COLS        = tcw_pkg::COLS_DEF,
  parameter int ROWS        = tcw_pkg::ROWS_DEF,
  parameter int STORE_CELLS = tcw_pkg::STORE_CELLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tcw_pkg::tcw_in_t  in_item,
  output logic              out_strobe,
  output tcw_pkg::tcw_out_t out_item
);

  import tcw_pkg::*;

  localparam int AW = $clog2(STORE_CELLS);

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  tcw_ctrl #(
    .COLS        (COLS),
    .ROWS        (ROWS),
    .STORE_CELLS (STORE_CELLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  tcw_cell_ram #(
    .DEPTH (STORE_CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic take;
  logic rd_hit;

  assign take   = start && !busy;
  assign rd_hit = take && (in_item.cmd == CMD_READ) &&
                  ({2'b00, in_item.cell_index} < 15'(STORE_CELLS));

`include "text_console_writer_unit_assert.svh"

  `TCW_ASSERT_SAME(a_read_two_cycles, rd_hit, ##1 busy ##1 out_strobe, "read result late")
  `TCW_ASSERT_NEXT(a_none_one_cycle, take && (in_item.cmd == CMD_NONE),
                   out_strobe && !busy && (out_item.read_data == 16'd0),
                   "unused command result wrong")
  `TCW_ASSERT_SAME(a_result_has_item, out_strobe, $past(take) || $past(busy),
                   "result without an item")

endmodule
